>>> hw/rtl/task_wait_object_scheduler_defines.svh
// Assertion macros for the task scheduler RTL.
// Used by files that carry concurrent checks; no other dependencies.
`ifndef TASK_WAIT_OBJECT_SCHEDULER_DEFINES_SVH
`define TASK_WAIT_OBJECT_SCHEDULER_DEFINES_SVH

`ifndef ASSERT_OFF
`define TWS_ASSERT(lbl, clk, rstn, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
		else $error("%m: check failed");
`define TWS_ASSERT_NEVER(lbl, clk, rstn, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) !(prop)) \
		else $error("%m: forbidden condition seen");
`else
`define TWS_ASSERT(lbl, clk, rstn, prop)
`define TWS_ASSERT_NEVER(lbl, clk, rstn, prop)
`endif

`endif

>>> hw/rtl/tws_pkg.sv
// Shared constants, types and helpers for the task scheduler.
// No dependencies; used by the interfaces and all modules.
`default_nettype none

package tws_pkg;

	localparam int TASK_COUNT = 8;
	localparam int SLOT_W     = (TASK_COUNT > 1) ? $clog2(TASK_COUNT) : 1;
	localparam int CNT_W      = $clog2(TASK_COUNT + 1);

	// field widths of the event and result transfers
	localparam int KIND_W = 2;
	localparam int IDX_W  = 3;
	localparam int OBJ_W  = 8;

	typedef enum logic [KIND_W-1:0] {
		K_ENABLE  = 2'd0,
		K_WAIT    = 2'd1,
		K_RELEASE = 2'd2,
		K_END     = 2'd3
	} kind_t;

	typedef logic [SLOT_W-1:0] slot_t;

	typedef struct packed {
		logic             en;
		logic             wt;
		logic [OBJ_W-1:0] obj;
	} entry_t;

	typedef struct packed {
		logic   rd_en;
		slot_t  rd_addr;
		logic   wr_en;
		slot_t  wr_addr;
		entry_t wr_data;
	} tbl_req_t;

	// value a slot holds until it is first written
	function automatic entry_t reset_entry(slot_t a);
		entry_t e;
		e.en  = (32'(a) >= 32'(TASK_COUNT - 2));
		e.wt  = 1'b0;
		e.obj = '0;
		return e;
	endfunction

endpackage

`default_nettype wire

>>> hw/rtl/tws_ifs.sv
// Valid/ready channel interfaces for scheduler events and results.
// Depends on tws_pkg for field widths.
`default_nettype none

interface tws_evt_if;
	logic                        valid;
	logic                        ready;
	logic [tws_pkg::KIND_W-1:0]  kind;
	logic [tws_pkg::IDX_W-1:0]   slot_index;
	logic [tws_pkg::OBJ_W-1:0]   object_id;

	modport source(output valid, output kind, output slot_index, output object_id,
		input ready);
	modport sink(input valid, input kind, input slot_index, input object_id,
		output ready);
endinterface

interface tws_res_if;
	logic                       valid;
	logic                       ready;
	logic [tws_pkg::IDX_W-1:0]  running_index;
	logic                       woke_task;
	logic                       no_ready_task;

	modport source(output valid, output running_index, output woke_task,
		output no_ready_task, input ready);
	modport sink(input valid, input running_index, input woke_task,
		input no_ready_task, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/task_wait_object_scheduler.sv
// Fixed-priority task scheduler, one result per event.
// Enable: slot written at transfer, then the output state loads the result. Wait and end: slot
// read-modify-write, then a pipelined scan of the slot table. Release: scan only.
// A new event is taken while a finished result waits in the output register.
// Reset (arst_n low) sets slots TASK_COUNT-1 and TASK_COUNT-2 enabled, running TASK_COUNT-2.
`default_nettype none

module task_wait_object_scheduler (
	input  logic      clk,
	input  logic      arst_n,
	tws_evt_if.sink   evt,
	tws_res_if.source res
);
	import tws_pkg::*;

	tbl_req_t tbl;
	entry_t   rd_data;

	tws_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.evt     (evt),
		.res     (res),
		.tbl     (tbl),
		.rd_data (rd_data)
	);

	tws_table u_table (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (tbl),
		.rd_data (rd_data)
	);

endmodule

`default_nettype wire

>>> hw/rtl/tws_table.sv
// Slot table: one synchronous memory with a single write and a single read port.
// Entries never written read back as their reset value. Depends on tws_pkg.
`default_nettype none

module tws_table (
	input  logic              clk,
	input  logic              arst_n,
	input  tws_pkg::tbl_req_t req,
	output tws_pkg::entry_t   rd_data
);
	import tws_pkg::*;

	entry_t                mem [TASK_COUNT];
	logic [TASK_COUNT-1:0] vld_q;
	entry_t                mem_rd_s1;
	logic                  rd_vld_s1;
	slot_t                 rd_addr_s1;

	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem[req.wr_addr] <= req.wr_data;
		end
		if (req.rd_en) begin
			mem_rd_s1  <= mem[req.rd_addr];
			rd_addr_s1 <= req.rd_addr;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q     <= '0;
			rd_vld_s1 <= 1'b0;
		end else begin
			if (req.wr_en) begin
				vld_q[req.wr_addr] <= 1'b1;
			end
			if (req.rd_en) begin
				rd_vld_s1 <= vld_q[req.rd_addr];
			end
		end
	end

	assign rd_data = rd_vld_s1 ? mem_rd_s1 : reset_entry(rd_addr_s1);

endmodule

`default_nettype wire

>>> hw/rtl/tws_ctrl.sv
// Event sequencer: read-modify-write of the running slot, pipelined slot scan,
// result register. Depends on tws_pkg, tws_ifs and the assertion macro header.
`default_nettype none
`include "task_wait_object_scheduler_defines.svh"

module tws_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	tws_evt_if.sink           evt,
	tws_res_if.source         res,
	output tws_pkg::tbl_req_t tbl,
	input  tws_pkg::entry_t   rd_data
);
	import tws_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_RMW  = 4'b0010,
		ST_SCAN = 4'b0100,
		ST_OUT  = 4'b1000
	} state_t;

	state_t           state_q;
	kind_t            kind_q;
	logic [OBJ_W-1:0] obj_q;
	slot_t            run_q;
	logic [CNT_W-1:0] scan_q;
	logic             rv_s1;
	slot_t            ridx_s1;
	logic             woke_q;
	logic             none_q;

	logic             res_valid_q;
	logic [IDX_W-1:0] res_run_q;
	logic             res_woke_q;
	logic             res_none_q;

	logic  accept;
	kind_t evt_kind;
	logic  in_range;
	logic  issue;
	logic  hit;
	logic  last;
	logic  res_free;

	assign evt.ready = (state_q == ST_IDLE);
	assign accept    = evt.valid && evt.ready;
	assign evt_kind  = kind_t'(evt.kind);
	assign in_range  = 32'(evt.slot_index) < 32'(TASK_COUNT);
	assign issue     = (state_q == ST_SCAN) && (scan_q < CNT_W'(TASK_COUNT));
	assign last      = rv_s1 && (ridx_s1 == slot_t'(TASK_COUNT - 1));
	assign res_free  = !res_valid_q || res.ready;

	always_comb begin
		hit = 1'b0;
		if (rv_s1 && state_q == ST_SCAN) begin
			if (kind_q == K_RELEASE) begin
				hit = rd_data.en && rd_data.wt && (rd_data.obj == obj_q);
			end else begin
				hit = rd_data.en && !rd_data.wt;
			end
		end
	end

	always_comb begin
		tbl = '0;
		case (state_q)
			ST_IDLE: begin
				if (accept && evt_kind == K_ENABLE && in_range) begin
					tbl.wr_en       = 1'b1;
					tbl.wr_addr     = slot_t'(evt.slot_index);
					tbl.wr_data.en  = 1'b1;
					tbl.wr_data.wt  = 1'b0;
					tbl.wr_data.obj = '0;
				end
				if (accept && (evt_kind == K_WAIT || evt_kind == K_END)) begin
					tbl.rd_en   = 1'b1;
					tbl.rd_addr = run_q;
				end
			end
			ST_RMW: begin
				tbl.wr_en   = 1'b1;
				tbl.wr_addr = run_q;
				tbl.wr_data = rd_data;
				if (kind_q == K_WAIT) begin
					tbl.wr_data.wt  = 1'b1;
					tbl.wr_data.obj = obj_q;
				end else begin
					tbl.wr_data.en = 1'b0;
				end
			end
			ST_SCAN: begin
				tbl.rd_en   = issue;
				tbl.rd_addr = slot_t'(scan_q);
				// wake the matching waiter
				if (hit && kind_q == K_RELEASE) begin
					tbl.wr_en      = 1'b1;
					tbl.wr_addr    = ridx_s1;
					tbl.wr_data    = rd_data;
					tbl.wr_data.wt = 1'b0;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			kind_q <= evt_kind;
			obj_q  <= evt.object_id;
		end
		ridx_s1 <= slot_t'(scan_q);
		if (state_q == ST_OUT && res_free) begin
			res_run_q  <= IDX_W'(run_q);
			res_woke_q <= woke_q;
			res_none_q <= none_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			run_q       <= slot_t'(TASK_COUNT - 2);
			scan_q      <= '0;
			rv_s1       <= 1'b0;
			woke_q      <= 1'b0;
			none_q      <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			rv_s1 <= issue;
			if (state_q == ST_OUT && res_free) begin
				res_valid_q <= 1'b1;
			end else if (res.ready) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						woke_q <= 1'b0;
						none_q <= 1'b0;
						scan_q <= '0;
						case (evt_kind)
							K_ENABLE:  state_q <= ST_OUT;
							K_RELEASE: state_q <= ST_SCAN;
							default:   state_q <= ST_RMW;
						endcase
					end
				end
				ST_RMW: state_q <= ST_SCAN;
				ST_SCAN: begin
					if (issue) begin
						scan_q <= scan_q + 1'b1;
					end
					if (hit) begin
						run_q   <= ridx_s1;
						woke_q  <= (kind_q == K_RELEASE);
						state_q <= ST_OUT;
					end else if (last) begin
						none_q  <= (kind_q == K_END);
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (res_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign res.valid         = res_valid_q;
	assign res.running_index = res_run_q;
	assign res.woke_task     = res_woke_q;
	assign res.no_ready_task = res_none_q;

	`TWS_ASSERT_NEVER(a_rw_same_slot, clk, arst_n,
		tbl.rd_en && tbl.wr_en && (tbl.rd_addr == tbl.wr_addr))
	`TWS_ASSERT(a_run_in_table, clk, arst_n, 32'(run_q) < 32'(TASK_COUNT))
	`TWS_ASSERT_NEVER(a_woke_and_none, clk, arst_n,
		res_valid_q && res_woke_q && res_none_q)
	`TWS_ASSERT(a_load_from_out, clk, arst_n,
		$rose(res_valid_q) |-> $past(state_q == ST_OUT))
	`TWS_ASSERT(a_read_return_in_scan, clk, arst_n,
		rv_s1 |-> (state_q == ST_SCAN || state_q == ST_OUT))

endmodule

`default_nettype wire

>>> tb/testbench.sv
// Self-checking bench for the fixed-priority task scheduler: random and directed events,
// predicted results compared field by field. Depends on tws_pkg, tws_ifs and the RTL top.
`default_nettype none

module testbench;
	import tws_pkg::*;

	localparam int CYCLE_LIMIT   = 400000;
	localparam int RANDOM_EVENTS = 2000;
	localparam int HOLD_AT       = 700;
	localparam int HOLD_CYCLES   = 400;
	localparam int DRAIN_AT      = 1200;

	typedef struct {
		kind_t            kind;
		logic [IDX_W-1:0] slot;
		logic [OBJ_W-1:0] obj;
		int               gap;
		bit               drain;
	} sched_event_t;

	typedef struct {
		logic [IDX_W-1:0] running;
		logic             woke;
		logic             none;
	} sched_outcome_t;

	logic clk;
	logic arst_n;

	tws_evt_if evt_ch();
	tws_res_if res_ch();

	task_wait_object_scheduler u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.evt    (evt_ch),
		.res    (res_ch)
	);

	// scheduler state as the block should hold it
	bit               slot_on[TASK_COUNT];
	bit               slot_blocked[TASK_COUNT];
	logic [OBJ_W-1:0] slot_obj[TASK_COUNT];
	int               cur_slot;

	sched_event_t   event_backlog[$];
	sched_outcome_t due_outcomes[$];

	bit evt_busy, gap_armed, evt_took, res_took, hold_done;
	int gap_left, rx_gap, hold_left;
	int cycles, events_taken, results_seen, mismatches;
	int kind_seen[4];
	int wakeups, idle_ends;

	initial clk = 1'b0;
	always #5 clk = ~clk;

	function automatic int first_ready();
		for (int i = 0; i < TASK_COUNT; i++)
			if (slot_on[i] && !slot_blocked[i])
				return i;
		return -1;
	endfunction

	function automatic sched_outcome_t apply_event(sched_event_t ev);
		sched_outcome_t o;
		int pick;
		o.woke = 1'b0;
		o.none = 1'b0;
		if (cur_slot >= TASK_COUNT)
			cur_slot = 0;
		case (ev.kind)
			K_ENABLE: begin
				if (int'(ev.slot) < TASK_COUNT) begin
					slot_on[ev.slot]      = 1'b1;
					slot_blocked[ev.slot] = 1'b0;
					slot_obj[ev.slot]     = '0;
				end
			end
			K_WAIT: begin
				slot_obj[cur_slot]     = ev.obj;
				slot_blocked[cur_slot] = 1'b1;
				pick = first_ready();
				if (pick >= 0)
					cur_slot = pick;
			end
			K_RELEASE: begin
				for (int i = 0; i < TASK_COUNT; i++) begin
					if (slot_on[i] && slot_blocked[i] && slot_obj[i] == ev.obj) begin
						slot_blocked[i] = 1'b0;
						cur_slot = i;
						o.woke = 1'b1;
						break;
					end
				end
			end
			default: begin
				slot_on[cur_slot] = 1'b0;
				pick = first_ready();
				if (pick >= 0)
					cur_slot = pick;
				else
					o.none = 1'b1;
			end
		endcase
		o.running = IDX_W'(cur_slot);
		return o;
	endfunction

	task automatic add_event(kind_t k, logic [IDX_W-1:0] slot, logic [OBJ_W-1:0] obj,
		bit drain);
		sched_event_t ev;
		ev.kind  = k;
		ev.slot  = slot;
		ev.obj   = obj;
		ev.drain = drain;
		// every fourth block of events goes back to back
		ev.gap   = ((event_backlog.size() / 250) % 4 == 3) ? 0 : $urandom_range(0, 5);
		event_backlog.push_back(ev);
	endtask

	// sender: offer the next pending event after its gap, a drain event only once no result is due
	always @(negedge clk) begin : drive_events
		sched_event_t nxt;
		if (arst_n) begin
			if (evt_busy && evt_took)
				evt_busy = 1'b0;
			if (!evt_busy && event_backlog.size() > 0) begin
				if (!gap_armed) begin
					gap_left  = event_backlog[0].gap;
					gap_armed = 1'b1;
				end
				if (gap_left > 0)
					gap_left--;
				else if (!event_backlog[0].drain || due_outcomes.size() == 0) begin
					nxt = event_backlog.pop_front();
					evt_ch.kind       <= nxt.kind;
					evt_ch.slot_index <= nxt.slot;
					evt_ch.object_id  <= nxt.obj;
					evt_busy  = 1'b1;
					gap_armed = 1'b0;
				end
			end
			evt_ch.valid <= evt_busy;
		end
	end

	// receiver: random stalls per result, one long hold-off to back up the block
	always @(negedge clk) begin
		if (arst_n) begin
			if (!hold_done && events_taken >= HOLD_AT) begin
				hold_left = HOLD_CYCLES;
				hold_done = 1'b1;
			end
			if (res_took)
				rx_gap = ((results_seen / 250) % 4 == 1) ? 0 : $urandom_range(0, 5);
			if (hold_left > 0) begin
				hold_left--;
				res_ch.ready <= 1'b0;
			end else if (rx_gap > 0) begin
				rx_gap--;
				res_ch.ready <= 1'b0;
			end else begin
				res_ch.ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin : observe
		sched_outcome_t want;
		sched_event_t   got;
		if (arst_n) begin
			cycles++;
			evt_took <= evt_ch.valid && evt_ch.ready;
			res_took <= res_ch.valid && res_ch.ready;
			if (res_ch.valid && res_ch.ready) begin
				results_seen++;
				if (due_outcomes.size() == 0) begin
					$error("unexpected result: running_index=%0d woke_task=%0b no_ready_task=%0b",
						res_ch.running_index, res_ch.woke_task, res_ch.no_ready_task);
					mismatches++;
				end else begin
					want = due_outcomes.pop_front();
					if (res_ch.running_index !== want.running) begin
						$error("running_index: expected %0d, got %0d",
							want.running, res_ch.running_index);
						mismatches++;
					end
					if (res_ch.woke_task !== want.woke) begin
						$error("woke_task: expected %0b, got %0b", want.woke, res_ch.woke_task);
						mismatches++;
					end
					if (res_ch.no_ready_task !== want.none) begin
						$error("no_ready_task: expected %0b, got %0b",
							want.none, res_ch.no_ready_task);
						mismatches++;
					end
				end
			end
			if (evt_ch.valid && evt_ch.ready) begin
				got.kind = kind_t'(evt_ch.kind);
				got.slot = evt_ch.slot_index;
				got.obj  = evt_ch.object_id;
				want = apply_event(got);
				due_outcomes.push_back(want);
				events_taken++;
				kind_seen[evt_ch.kind]++;
				wakeups   += want.woke;
				idle_ends += want.none;
			end
			if (cycles > CYCLE_LIMIT) begin
				$display("TEST FAILED");
				$finish;
			end
		end
	end

	initial begin
		int r;
		kind_t k;
		logic [OBJ_W-1:0] obj_pool[4];

		arst_n            = 1'b0;
		evt_ch.valid      = 1'b0;
		evt_ch.kind       = K_ENABLE;
		evt_ch.slot_index = '0;
		evt_ch.object_id  = '0;
		res_ch.ready      = 1'b0;
		for (int i = 0; i < TASK_COUNT; i++) begin
			slot_on[i]      = (i >= TASK_COUNT - 2);
			slot_blocked[i] = 1'b0;
			slot_obj[i]     = '0;
		end
		cur_slot = TASK_COUNT - 2;

		// wake and disable paths starting from the reset table
		add_event(K_WAIT,    3'd0, 8'h00, 1'b0);
		add_event(K_RELEASE, 3'd7, 8'h00, 1'b0);
		add_event(K_RELEASE, 3'd1, 8'h5a, 1'b0);
		add_event(K_END,     3'd2, 8'h33, 1'b0);
		add_event(K_END,     3'd5, 8'hcc, 1'b0);
		// end again with the running slot already off
		add_event(K_END,     3'd0, 8'h00, 1'b0);
		// wait on a disabled running slot, then release must not wake it
		add_event(K_WAIT,    3'd3, 8'hff, 1'b0);
		add_event(K_RELEASE, 3'd4, 8'hff, 1'b0);
		for (int s = 0; s < 8; s++)
			add_event(K_ENABLE, 3'(s), (s % 2) ? 8'hff : 8'h00, 1'b0);
		add_event(K_WAIT,    3'd6, 8'haa, 1'b0);
		add_event(K_WAIT,    3'd1, 8'h55, 1'b0);
		add_event(K_RELEASE, 3'd2, 8'h55, 1'b1);
		add_event(K_RELEASE, 3'd0, 8'haa, 1'b0);
		add_event(K_WAIT,    3'd7, 8'h00, 1'b0);
		// re-enable clears the wait, so id zero no longer matches
		add_event(K_ENABLE,  3'd7, 8'h81, 1'b0);
		add_event(K_RELEASE, 3'd5, 8'h00, 1'b0);
		add_event(K_END,     3'd6, 8'h7e, 1'b0);

		// a few ids reused so that releases find waiters
		obj_pool = '{8'h00, 8'h3c, 8'hc3, 8'hff};
		for (int n = 0; n < RANDOM_EVENTS; n++) begin
			r = $urandom_range(0, 99);
			k = (r < 22) ? K_ENABLE : (r < 50) ? K_WAIT : (r < 80) ? K_RELEASE : K_END;
			add_event(k, 3'($urandom_range(0, 7)),
				($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
					: obj_pool[$urandom_range(0, 3)],
				n == DRAIN_AT);
		end

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (event_backlog.size() != 0 || evt_busy || due_outcomes.size() != 0)
			@(posedge clk);
		repeat (30) @(posedge clk);

		$display("Ran %0d events: %0d enable, %0d wait, %0d release, %0d end.",
			events_taken, kind_seen[K_ENABLE], kind_seen[K_WAIT], kind_seen[K_RELEASE],
			kind_seen[K_END]);
		$display("Checked %0d results: %0d wake-ups, %0d ends with no ready task.",
			results_seen, wakeups, idle_ends);
		if (mismatches == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

`default_nettype wire

>>> files.f
+incdir+hw/rtl
hw/rtl/tws_pkg.sv
hw/rtl/tws_ifs.sv
hw/rtl/tws_table.sv
hw/rtl/tws_ctrl.sv
hw/rtl/task_wait_object_scheduler.sv
tb/testbench.sv
